>>> src/lhlh_pkg.sv
// Package: shared constants, command codes, log table and controller/datapath interface types.
`timescale 1ns / 1ps
package lhlh_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int NUM_BINS            = 256;
   localparam int BIN_WIDTH           = 8;
   localparam int PIXEL_WIDTH         = 24;
   localparam int HEIGHT_WIDTH        = 12;
   localparam int RESULT_COUNT_WIDTH  = 32;
   localparam int RATIO_BITS          = 28;
   localparam int RATIO_WIDTH         = RATIO_BITS + 1;
   localparam int ITER_WIDTH          = 5;
   localparam logic [HEIGHT_WIDTH-1:0] FULL_ROWS_RESET = 12'd128;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // controller -> datapath commands
   typedef struct packed {
      logic clear_step;   // write zero to sweep address, zero total
      logic pixel_rd;     // read bin of luma of pixel, capture luma
      logic pixel_wr;     // write incremented bin and total
      logic query_rd;     // read queried bin
      logic div_start;    // load divider from read data
      logic div_step;     // one restoring division step
      logic norm_step;    // one normalize shift
      logic finish;       // compute height into result register
   } lhlh_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic sweep_last;
      logic div_last;
      logic norm_done;
   } lhlh_status_type;

   function automatic logic [3:0] log_lookup(input logic [7:0] idx);
      logic [3:0] v;
      begin
         if (idx < 8'd24)       v = 4'd8;
         else if (idx < 8'd49)  v = 4'd7;
         else if (idx < 8'd76)  v = 4'd6;
         else if (idx < 8'd107) v = 4'd5;
         else if (idx < 8'd139) v = 4'd4;
         else if (idx < 8'd175) v = 4'd3;
         else if (idx < 8'd214) v = 4'd2;
         else                   v = 4'd1;
         return v;
      end
   endfunction

endpackage

>>> src/luma_histogram_log_height_unit.sv
// Top level: luma histogram with log-scaled bar height queries.
// Pixel transaction: bin read, then increment write; one at a time.
// Query transaction, from the accept cycle through the response cycle:
//   bin read, 28 divider steps, normalize shifts, finish; the response holds until taken.
// Clear transaction: accept cycle, then a sweep over all 256 bin memory entries, one entry a cycle.
// Reset (synchronous) runs the same sweep; no transaction is accepted until done.
`timescale 1ns / 1ps
module luma_histogram_log_height_unit
   import lhlh_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [PIXEL_WIDTH-1:0]        req_pixel,
   input  logic [BIN_WIDTH-1:0]          req_bin,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [HEIGHT_WIDTH-1:0]       rsp_bar_height,
   output logic [RESULT_COUNT_WIDTH-1:0] rsp_bin_count,
   input  logic                          csr_write,
   input  logic [HEIGHT_WIDTH-1:0]       csr_full_rows
);

   lhlh_cmd_type    cmd;
   lhlh_status_type status;
   logic [HEIGHT_WIDTH-1:0] full_rows_ff;

   // full-bar height register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset)          full_rows_ff <= FULL_ROWS_RESET;
      else if (csr_write) full_rows_ff <= csr_full_rows;
   end

   lhlh_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status)
   );

   lhlh_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .pixel        (req_pixel),
      .bin          (req_bin),
      .full_rows    (full_rows_ff),
      .bar_height   (rsp_bar_height),
      .bin_count    (rsp_bin_count)
   );

endmodule

>>> src/lhlh_datapath.sv
// Datapath: bin memory, total counter, luma, ratio divider, normalizer and height math.
`timescale 1ns / 1ps
module lhlh_datapath
   import lhlh_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lhlh_cmd_type                  cmd,
   output lhlh_status_type               status,
   input  logic [PIXEL_WIDTH-1:0]        pixel,
   input  logic [BIN_WIDTH-1:0]          bin,
   input  logic [HEIGHT_WIDTH-1:0]       full_rows,
   output logic [HEIGHT_WIDTH-1:0]       bar_height,
   output logic [RESULT_COUNT_WIDTH-1:0] bin_count
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_EMPTY  = 2'd1;
   localparam logic [1:0] KIND_FULL   = 2'd2;

   logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [BIN_WIDTH-1:0]   addr_ff, addr_in;
   logic [BIN_WIDTH-1:0]   sweep_ff, sweep_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH:0]   rem_ff, rem_in;
   logic [RATIO_WIDTH-1:0] quo_ff, quo_in;
   logic [ITER_WIDTH-1:0]  iter_ff, iter_in;
   logic [HEIGHT_WIDTH-1:0] shift_ff, shift_in;
   logic [1:0]             kind_ff, kind_in;
   logic [HEIGHT_WIDTH-1:0] bar_ff, bar_in;
   logic [RESULT_COUNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [16:0]            luma_sum;
   logic [BIN_WIDTH-1:0]   luma;
   logic [COUNT_WIDTH:0]   rem_dbl;
   logic                   mem_we;
   logic [COUNT_WIDTH-1:0] mem_wd;
   logic [BIN_WIDTH-1:0]   mem_wa;
   logic [RATIO_WIDTH-1:0] h_round;
   logic signed [HEIGHT_WIDTH+2:0] height;

   always_comb begin
      luma_sum = 17'(54 * pixel[23:16]) + 17'(183 * pixel[15:8]) + 17'(19 * pixel[7:0]);
      luma     = luma_sum[15:8];
   end

   // memory port
   always_comb begin
      mem_we = cmd.clear_step | cmd.pixel_wr;
      mem_wa = cmd.clear_step ? sweep_ff : addr_ff;
      mem_wd = cmd.clear_step ? '0
             : ((rd_data_ff == COUNT_MAX) ? rd_data_ff : rd_data_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[addr_in];
   end

   always_comb begin
      addr_in  = addr_ff;
      sweep_in = sweep_ff;
      total_in = total_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      iter_in  = iter_ff;
      shift_in = shift_ff;
      kind_in  = kind_ff;
      bar_in   = bar_ff;
      cnt_in   = cnt_ff;
      rem_dbl  = {rem_ff[COUNT_WIDTH-1:0], 1'b0};
      h_round  = '0;
      height   = '0;
      if (cmd.pixel_rd) addr_in = luma;
      if (cmd.query_rd) addr_in = bin;
      if (cmd.clear_step) begin
         sweep_in = sweep_ff + 1'b1;
         total_in = '0;
      end
      if (cmd.pixel_wr && total_ff != COUNT_MAX) total_in = total_ff + 1'b1;
      if (cmd.div_start) begin
         cnt_in   = RESULT_COUNT_WIDTH'(rd_data_ff);
         rem_in   = {1'b0, rd_data_ff};
         quo_in   = '0;
         iter_in  = '0;
         shift_in = '0;
         if (rd_data_ff == '0)            kind_in = KIND_EMPTY;
         else if (rd_data_ff >= total_ff) kind_in = KIND_FULL;
         else                             kind_in = KIND_NORMAL;
      end
      if (cmd.div_step) begin
         iter_in = iter_ff + 1'b1;
         if (rem_dbl >= {1'b0, total_ff}) begin
            rem_in = rem_dbl - {1'b0, total_ff};
            quo_in = {quo_ff[RATIO_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_dbl;
            quo_in = {quo_ff[RATIO_WIDTH-2:0], 1'b0};
         end
         if (iter_ff == ITER_WIDTH'(RATIO_BITS - 1)) begin
            // round half up on the final step
            rem_dbl = {rem_in[COUNT_WIDTH-1:0], 1'b0};
            if (rem_dbl >= {1'b0, total_ff}) quo_in = quo_in + 1'b1;
         end
      end
      if (cmd.norm_step) begin
         quo_in   = {quo_ff[RATIO_WIDTH-2:0], 1'b0};
         shift_in = shift_ff + 1'b1;
      end
      if (cmd.finish) begin
         // shift count is one above the octave index, hence the extra 8
         h_round = quo_ff;
         height  = $signed({3'b000, full_rows}) + 15'sd8
                 - $signed({3'b000, shift_ff[HEIGHT_WIDTH-4:0], 3'b000})
                 - $signed(15'(log_lookup(h_round[27:20])));
         if (kind_ff == KIND_EMPTY)     bar_in = '0;
         else if (kind_ff == KIND_FULL) bar_in = full_rows;
         else if (quo_ff == '0)         bar_in = 12'd1;
         else if (height < 15'sd1)      bar_in = 12'd1;
         else                           bar_in = height[HEIGHT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         total_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
         total_ff <= total_in;
      end
      addr_ff  <= addr_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      iter_ff  <= iter_in;
      shift_ff <= shift_in;
      kind_ff  <= kind_in;
      bar_ff   <= bar_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      status.sweep_last = (sweep_ff == '1);
      status.div_last   = (iter_ff == ITER_WIDTH'(RATIO_BITS - 1));
      // normalized when top bit set, or nothing to do
      status.norm_done  = quo_ff[RATIO_BITS] | (quo_ff == '0) | (kind_ff != KIND_NORMAL);
   end

   assign bar_height = bar_ff;
   assign bin_count  = cnt_ff;

endmodule

>>> src/lhlh_controller.sv
// Controller: sequences clear sweep, pixel read-modify-write and query division.
`timescale 1ns / 1ps
module lhlh_controller
   import lhlh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_command,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lhlh_cmd_type    cmd,
   input  lhlh_status_type status
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PWR   = 3'd2;
   localparam logic [2:0] ST_QLOAD = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_NORM  = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;
   localparam logic [2:0] ST_RSP   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = (state_ff == ST_RSP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_PIXEL: begin
                     cmd.pixel_rd = 1'b1;
                     state_in     = ST_PWR;
                  end
                  CMD_QUERY: begin
                     cmd.query_rd = 1'b1;
                     state_in     = ST_QLOAD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PWR: begin
            cmd.pixel_wr = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_QLOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) state_in = ST_FIN;
            else cmd.norm_step = 1'b1;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_RSP;
         end
         ST_RSP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FIN)) else $error("response without finish");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("multiple datapath commands");
`endif

endmodule

>>> tb/sv/luma_histogram_log_height_unit_test.sv
// Testbench for the luma histogram unit: directed and random transactions, checked against a predictor.
`timescale 1ns / 1ps
module luma_histogram_log_height_unit_test;
   import lhlh_pkg::*;

   // Code the block must ignore: no state change, no response.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 320;   // covers a 256-entry clear sweep
   localparam int CYCLE_LIMIT   = 600000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_command = CMD_CLEAR;
   logic [PIXEL_WIDTH-1:0]        req_pixel = '0;
   logic [BIN_WIDTH-1:0]          req_bin = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [HEIGHT_WIDTH-1:0]       rsp_bar_height;
   logic [RESULT_COUNT_WIDTH-1:0] rsp_bin_count;
   logic                          csr_write = 1'b0;
   logic [HEIGHT_WIDTH-1:0]       csr_full_rows = '0;

   luma_histogram_log_height_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_pixel(req_pixel), .req_bin(req_bin),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bar_height(rsp_bar_height), .rsp_bin_count(rsp_bin_count),
      .csr_write(csr_write), .csr_full_rows(csr_full_rows)
   );

   always #1 clock = ~clock;

   // Predictor state: our own copy of the histogram and the height register.
   logic [31:0]             hist_bins [NUM_BINS];
   logic [31:0]             hist_total;
   logic [HEIGHT_WIDTH-1:0] full_height;

   typedef struct {
      logic [HEIGHT_WIDTH-1:0]       bar_height;
      logic [RESULT_COUNT_WIDTH-1:0] bin_count;
   } bar_answer_type;

   bar_answer_type pending_answers [$];
   int          fail_count = 0;
   int          cycle_count = 0;

   // Sender burst shaping.
   int burst_left = 0;
   // Palette of colors for the current phase; concentrates pixels in few bins.
   logic [PIXEL_WIDTH-1:0] palette [6];

   function automatic logic [7:0] luma_of(logic [PIXEL_WIDTH-1:0] px);
      logic [17:0] sum;
      sum = 18'd54 * px[23:16] + 18'd183 * px[15:8] + 18'd19 * px[7:0];
      return sum[15:8];
   endfunction

   // Eighth-octave correction: 8 minus the number of step points at or below idx.
   function automatic int octave_fraction(logic [7:0] idx);
      int steps [7] = '{24, 49, 76, 107, 139, 175, 214};
      int v;
      v = 8;
      foreach (steps[i]) if (idx >= steps[i]) v--;
      return v;
   endfunction

   function automatic logic [HEIGHT_WIDTH-1:0] log_bar_height(logic [31:0] cnt);
      longint unsigned q, r, den;
      int shifts, ht;
      if (cnt == 0) return '0;
      if (cnt >= hist_total) return full_height;
      den = hist_total;
      q = 0;
      r = cnt;
      // ratio to 2^28 scale, round half up
      for (int i = 0; i < RATIO_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      if ((r << 1) >= den) q++;
      if (q == 0) return 12'd1;
      shifts = -1;
      while (q < (64'd1 << RATIO_BITS)) begin
         q = q << 1;
         shifts++;
      end
      ht = int'(full_height) - 8 * shifts - octave_fraction(8'((q >> 20) & 255));
      if (ht < 1) ht = 1;
      return ht[HEIGHT_WIDTH-1:0];
   endfunction

   // Apply one accepted transaction to the predictor.
   task automatic predict_transaction(logic [1:0] cmd, logic [PIXEL_WIDTH-1:0] px,
                                      logic [BIN_WIDTH-1:0] b);
      bar_answer_type ans;
      logic [7:0]  y;
      case (cmd)
         CMD_CLEAR: begin
            foreach (hist_bins[i]) hist_bins[i] = '0;
            hist_total = '0;
         end
         CMD_PIXEL: begin
            y = luma_of(px);
            if (hist_bins[y] != 32'hFFFF_FFFF) hist_bins[y]++;
            if (hist_total != 32'hFFFF_FFFF) hist_total++;
         end
         CMD_QUERY: begin
            ans.bar_height = log_bar_height(hist_bins[b]);
            ans.bin_count  = hist_bins[b];
            pending_answers.push_back(ans);
         end
         default: ;
      endcase
   endtask

   // Send one transaction; holds it until accepted, then maybe opens a gap.
   task automatic send_transaction(logic [1:0] cmd, logic [PIXEL_WIDTH-1:0] px,
                                   logic [BIN_WIDTH-1:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_pixel   <= px;
      req_bin     <= b;
      do @(posedge clock); while (req_stall);
      predict_transaction(cmd, px, b);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                : $urandom_range(0, 12);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Block is idle once every answer is in and any clear sweep has finished.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_full_height(logic [HEIGHT_WIDTH-1:0] value);
      wait_idle();
      csr_write     <= 1'b1;
      csr_full_rows <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      full_height = value;
   endtask

   task automatic new_palette();
      foreach (palette[i]) palette[i] = $urandom_range(0, 24'hFFFFFF);
   endtask

   task automatic test_directed();
      send_transaction(CMD_QUERY, 24'h000000, 8'd0);      // empty bin
      send_transaction(CMD_PIXEL, 24'h000000, 8'd0);      // black -> bin 0
      send_transaction(CMD_QUERY, 24'hFFFFFF, 8'd0);      // full bar
      send_transaction(CMD_PIXEL, 24'hFFFFFF, 8'hFF);     // white -> bin 255
      send_transaction(CMD_PIXEL, 24'hFF0000, 8'd0);
      send_transaction(CMD_PIXEL, 24'h00FF00, 8'd0);
      send_transaction(CMD_PIXEL, 24'h0000FF, 8'd0);
      send_transaction(CMD_PIXEL, 24'hAAAAAA, 8'd0);
      send_transaction(CMD_PIXEL, 24'h555555, 8'd0);
      send_transaction(CMD_QUERY, 24'h000000, 8'hFF);
      send_transaction(CMD_QUERY, 24'h000000, 8'd0);
      send_transaction(CMD_QUERY, 24'h000000, luma_of(24'h00FF00));
      send_transaction(CMD_UNUSED, 24'hFFFFFF, 8'hFF);    // ignored
      send_transaction(CMD_QUERY, 24'h000000, 8'd128);    // empty bin with pixels present
      send_transaction(CMD_CLEAR, 24'hFFFFFF, 8'hFF);
      send_transaction(CMD_QUERY, 24'h000000, 8'hFF);     // cleared
      send_transaction(CMD_PIXEL, 24'h808080, 8'd0);
      send_transaction(CMD_QUERY, 24'h000000, luma_of(24'h808080));
   endtask

   // Saturated-style extremes of the height register: clamp to 1 and the top value.
   task automatic test_height_extremes();
      write_full_height(12'd0);
      send_transaction(CMD_PIXEL, 24'h000000, 8'd0);
      send_transaction(CMD_QUERY, 24'h000000, 8'd255);
      send_transaction(CMD_QUERY, 24'h000000, 8'd0);
      write_full_height(12'hFFF);
      send_transaction(CMD_QUERY, 24'h000000, 8'd255);
      send_transaction(CMD_QUERY, 24'h000000, 8'd0);
   endtask

   // One phase of random traffic, mostly pixels from a small palette.
   task automatic test_random_traffic(int items);
      int               pick;
      logic [1:0]       cmd;
      logic [PIXEL_WIDTH-1:0] px;
      logic [BIN_WIDTH-1:0]   b;
      new_palette();
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         px   = $urandom_range(0, 24'hFFFFFF);
         b    = $urandom_range(0, 255);
         if (pick < 2)       cmd = CMD_CLEAR;
         else if (pick < 5)  cmd = CMD_UNUSED;
         else if (pick < 30) cmd = CMD_QUERY;
         else                cmd = CMD_PIXEL;
         if (cmd == CMD_PIXEL && $urandom_range(0, 9) < 7)
            px = palette[$urandom_range(0, 5)];
         if (cmd == CMD_QUERY && $urandom_range(0, 1) == 1)
            b = luma_of(palette[$urandom_range(0, 5)]);
         if (n == items / 2) begin
            // hold off until the block has drained every answer
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_answers.size() != 0) @(posedge clock);
         end
         send_transaction(cmd, px, b);
      end
   endtask

   // Receiver stall pattern: alternating stretches of free flow and random stalls.
   int stall_mode_left = 0;
   bit stall_mode = 1'b0;
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = $urandom_range(0, 1);
         stall_mode_left = $urandom_range(50, 400);
      end else begin
         stall_mode_left--;
      end
      rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
   end

   // Response checker: every taken response against the oldest expectation.
   always @(posedge clock) begin
      bar_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response: bar_height %0d bin_count %0d",
                   rsp_bar_height, rsp_bin_count);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bar_height !== want.bar_height) begin
               $error("bar_height expected %0d actual %0d", want.bar_height, rsp_bar_height);
               fail_count++;
            end
            if (rsp_bin_count !== want.bin_count) begin
               $error("bin_count expected %0d actual %0d", want.bin_count, rsp_bin_count);
               fail_count++;
            end
         end
      end
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("luma_histogram_log_height_unit_test NOT OK");
         $finish;
      end
   end

   initial begin
      foreach (hist_bins[i]) hist_bins[i] = '0;
      hist_total  = '0;
      full_height = FULL_ROWS_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_height_extremes();
      write_full_height(FULL_ROWS_RESET);
      test_random_traffic(130);
      write_full_height(12'd1);
      test_random_traffic(90);
      write_full_height(12'hFFF);
      test_random_traffic(110);
      write_full_height(12'd0);
      test_random_traffic(80);
      write_full_height($urandom_range(0, 4095));
      test_random_traffic(110);

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("luma_histogram_log_height_unit_test OK");
      else
         $display("luma_histogram_log_height_unit_test NOT OK");
      $finish;
   end

endmodule

>>> files.f
src/lhlh_pkg.sv
src/lhlh_datapath.sv
src/lhlh_controller.sv
src/luma_histogram_log_height_unit.sv
tb/sv/luma_histogram_log_height_unit_test.sv
